// ===== src/b64sd_pkg.sv =====
// shared types, constants and the character classifier for the base64 stream decoder
// no dependencies
package b64sd_pkg;

    // alphabet selector codes
    localparam logic [1:0] ALPHA_STD  = 2'd0;
    localparam logic [1:0] ALPHA_URL  = 2'd1;
    localparam logic [1:0] ALPHA_BOTH = 2'd2;

    // configuration register indexes
    localparam logic CFG_ALPHABET = 1'b0;
    localparam logic CFG_IGNORE   = 1'b1;

    // result status codes
    localparam logic STATUS_DATA  = 1'b0;
    localparam logic STATUS_ERROR = 1'b1;

    // whitespace characters that are dropped
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;

    typedef struct packed {
        logic       valid;
        logic [5:0] value;
    } t_sextet;

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) ||
               (c == CH_FF) || (c == CH_CR);
    endfunction

    // map a saturated character to its sextet under the selected alphabet
    function automatic t_sextet sextet_of(input logic [7:0] c, input logic [1:0] alpha);
        t_sextet    res;
        logic       std_ok;
        logic       url_ok;
        logic [7:0] diff;
        std_ok = (alpha != ALPHA_URL);
        url_ok = (alpha != ALPHA_STD);
        res    = '{valid: 1'b0, value: 6'd0};
        diff   = 8'd0;
        if (c >= 8'h41 && c <= 8'h5A) begin
            diff = c - 8'h41;
            res  = '{valid: 1'b1, value: diff[5:0]};
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            diff = c - 8'h61 + 8'd26;
            res  = '{valid: 1'b1, value: diff[5:0]};
        end else if (c >= 8'h30 && c <= 8'h39) begin
            diff = c - 8'h30 + 8'd52;
            res  = '{valid: 1'b1, value: diff[5:0]};
        end else if (std_ok && c == 8'h2B) begin
            res = '{valid: 1'b1, value: 6'd62};
        end else if (std_ok && c == 8'h2F) begin
            res = '{valid: 1'b1, value: 6'd63};
        end else if (url_ok && c == 8'h2D) begin
            res = '{valid: 1'b1, value: 6'd62};
        end else if (url_ok && c == 8'h5F) begin
            res = '{valid: 1'b1, value: 6'd63};
        end
        return res;
    endfunction

endpackage

// ===== src/base64_stream_decoder_core.sv =====
// base64 stream decoder, standard and url alphabets, one code unit per transfer
// depends on b64sd_pkg
//
//  channel  | direction | handshake                 | payload
//  ---------+-----------+---------------------------+----------------------------------
//  input    | in        | i_in_valid / o_in_ready   | i_code_unit[15:0]
//  result   | out       | o_out_valid / i_out_ready | o_status, o_byte_first/second/third
//  config   | in        | i_cfg_we (no wait)        | i_cfg_index[0], i_cfg_data[1:0]
//
// one code unit per cycle sustained while the result channel takes results; an input
// transfer reaches the result through the input register, then the result register
// the group state updates when an item leaves the input register
// an item that makes a result waits in the input register only while the result
// register holds an untaken result; dropped characters never wait
// synchronous active-low reset clears config, group state and valid flags
module base64_stream_decoder_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [15:0] i_code_unit,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_status,
    output logic [7:0]  o_byte_first,
    output logic [7:0]  o_byte_second,
    output logic [7:0]  o_byte_third,
    // configuration writes
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [1:0]  i_cfg_data
);

    // config registers
    logic [1:0]  r_alphabet;
    logic        r_ignore;

    // input register, holds the saturated character
    logic        r_in_valid;
    logic [7:0]  r_in_char;

    // group state
    logic [17:0] r_acc;
    logic [1:0]  r_count;
    logic [17:0] n_acc;
    logic [1:0]  n_count;

    // result register
    logic        r_out_valid;
    logic        r_out_status;
    logic [7:0]  r_out_b1;
    logic [7:0]  r_out_b2;
    logic [7:0]  r_out_b3;
    logic        n_out_valid;

    b64sd_pkg::t_sextet sx;
    logic        has_result;
    logic        out_free;
    logic        advance;
    logic        is_err;
    logic [23:0] group;

    // config port, to be written only while idle; the block itself does not enforce this
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alphabet <= b64sd_pkg::ALPHA_STD;
            r_ignore   <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                b64sd_pkg::CFG_ALPHABET: r_alphabet <= i_cfg_data;
                b64sd_pkg::CFG_IGNORE:   r_ignore   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // classify the held character
    always_comb begin
        sx         = b64sd_pkg::sextet_of(r_in_char, r_alphabet);
        is_err     = !sx.valid && !b64sd_pkg::is_space(r_in_char) && !r_ignore;
        // a result comes from an error or from the fourth sextet of a group
        has_result = is_err || (sx.valid && (r_count == 2'd3));
        out_free   = !r_out_valid || i_out_ready;
        // dropped characters and sextets that do not complete a group move on without the output side
        advance    = r_in_valid && (out_free || !has_result);
        o_in_ready = !r_in_valid || advance;
        group      = {r_acc, sx.value};
    end

    // next group state
    always_comb begin
        n_acc   = r_acc;
        n_count = r_count;
        if (advance && sx.valid) begin
            if (r_count == 2'd3) begin
                n_acc   = 18'd0;
                n_count = 2'd0;
            end else begin
                n_acc   = {r_acc[11:0], sx.value};
                n_count = r_count + 2'd1;
            end
        end
        n_out_valid = (r_out_valid && !i_out_ready) || (advance && has_result);
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    // saturate wide units to 0xff, which is never a valid character
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_char <= (|i_code_unit[15:8]) ? 8'hFF : i_code_unit[7:0];
        end
    end

    // group state and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= 18'd0;
            r_count     <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_acc       <= n_acc;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // result payload, bytes are zero on error
    always_ff @(posedge i_clk) begin
        if (advance && has_result) begin
            if (is_err) begin
                r_out_status <= b64sd_pkg::STATUS_ERROR;
                r_out_b1     <= 8'd0;
                r_out_b2     <= 8'd0;
                r_out_b3     <= 8'd0;
            end else begin
                r_out_status <= b64sd_pkg::STATUS_DATA;
                r_out_b1     <= group[23:16];
                r_out_b2     <= group[15:8];
                r_out_b3     <= group[7:0];
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_byte_first  = r_out_b1;
    assign o_byte_second = r_out_b2;
    assign o_byte_third  = r_out_b3;

endmodule
